// ===== rtl/core/ecpp_pkg.sv =====
// -----------------------------------------------------------------------------
// ecpp_pkg - core placement policy shared definitions
// Types, codes and constants used by the controller, the datapath and the top.
// -----------------------------------------------------------------------------
package ecpp_pkg;

    localparam int MAX_CORES_DEF  = 8;
    localparam int MAX_PROPOSALS  = 8;

    localparam logic [6:0] LOAD_CAP    = 7'd100;
    localparam logic [3:0] RUN_SAT     = 4'd15;
    localparam logic [6:0] HI_TH_RST   = 7'd75;
    localparam logic [6:0] LO_TH_RST   = 7'd30;
    localparam logic [3:0] RUN_LEN_RST = 4'd3;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_SELECT  = 2'd1,
        CMD_BALANCE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SELECT   = 2'd0,
        KIND_PROPOSAL = 2'd1,
        KIND_DONE     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_CORE_COUNT = 3'd0,
        CFG_BIG_MASK   = 3'd1,
        CFG_HIGH_TH    = 3'd2,
        CFG_LOW_TH     = 3'd3,
        CFG_RUN_LEN    = 3'd4
    } t_cfg_idx;

    // read address source for the per-core state
    typedef enum logic [1:0] {
        ADDR_ID   = 2'd0,
        ADDR_SCAN = 2'd1,
        ADDR_CUR  = 2'd2
    } t_addr_sel;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] core_id;
        logic [7:0] load_percent;
        logic       wants_big;
        logic       on_solar;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] source_core;
        logic [2:0] target_core;
        logic [6:0] source_load;
        logic [6:0] target_load;
        logic [3:0] proposal_count;
        logic       last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic      latch_in;
        t_addr_sel addr_sel;
        logic      upd;
        logic      pick_start;
        logic      pick_step;
        logic      cur_latch;
        logic      next_core;
        logic      emit;
        t_kind     emit_kind;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       pick_done;
        logic       bal_done;
        logic       cand;
        logic       prop_ok;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/core/ewma_core_placement_policy.sv =====
// -----------------------------------------------------------------------------
// ewma_core_placement_policy - smoothed-load core placement with hysteresis
// One transaction in flight at a time; select and balance scan the cores in turn
// through the single state read port.
// Reset: i_rst_n synchronous, active low; config to defaults, state all zero.
// -----------------------------------------------------------------------------
//
// Structure
//   ecpp_ctrl : sequencer. Accepts a transaction only when idle and walks it
//               through update, scan and emit steps.
//   ecpp_dp   : config registers, per-core smoothed load and high/low run
//               counters, the scan unit and the result register.
//
// Scan unit
//   One pass over the active cores keeps two running minima: the least
//   loaded core of the wanted class and the least loaded core overall.
//   Strict less-than keeps ties on the lowest index. If no core of the
//   wanted class exists the overall minimum is used; with no active cores
//   the answer is core 0 at load 0.
//
// Balance
//   Each active core is tested in turn. A little core whose high run has
//   reached run_length asks for a big core; a big core whose low run has
//   reached run_length asks for a little one (solar still forces big).
//   A proposal is raised, and the run counter used is cleared, only when
//   the target differs from the core (and, for a little core, is less
//   loaded). The walk stops after eight proposals; a finishing transaction
//   carries the count.
//
// Result register
//   Decouples the two sides: a result can wait for o_out_valid/i_out_ready
//   while the sequencer returns to idle and takes the next transaction.
//
// Config port
//   Always ready. Writing core_count clears all per-core state at once.
// -----------------------------------------------------------------------------
module ewma_core_placement_policy #(
    parameter int MAX_CORES = ecpp_pkg::MAX_CORES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ecpp_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ecpp_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    ecpp_pkg::t_ctl ctl;
    ecpp_pkg::t_sts sts;

    // config is taken whenever offered
    assign o_cfg_ready = 1'b1;

    ecpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    ecpp_dp #(
        .MAX_CORES (MAX_CORES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/ecpp_ctrl.sv =====
// -----------------------------------------------------------------------------
// ecpp_ctrl - placement policy sequencer
// Walks update, select and balance transactions and drives the datapath.
// -----------------------------------------------------------------------------
module ecpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_cmd,
    output logic             o_in_ready,
    input  ecpp_pkg::t_sts   i_sts,
    output ecpp_pkg::t_ctl   o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_PICK,
        S_EMIT_SEL,
        S_BAL,
        S_CHK,
        S_EMIT_PROP,
        S_EMIT_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_ctl           = '0;
        o_ctl.addr_sel  = ecpp_pkg::ADDR_ID;
        o_ctl.emit_kind = ecpp_pkg::KIND_SELECT;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch_in = 1'b1;
                    case (i_cmd)
                        ecpp_pkg::CMD_UPDATE:  n_state = S_UPD;
                        ecpp_pkg::CMD_SELECT:  n_state = S_PICK;
                        ecpp_pkg::CMD_BALANCE: n_state = S_BAL;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_UPD: begin
                o_ctl.upd = 1'b1;
                n_state   = S_IDLE;
            end
            S_PICK: begin
                o_ctl.addr_sel = ecpp_pkg::ADDR_SCAN;
                if (i_sts.pick_done) begin
                    n_state = (i_sts.cmd == ecpp_pkg::CMD_SELECT) ? S_EMIT_SEL : S_CHK;
                end else begin
                    o_ctl.pick_step = 1'b1;
                end
            end
            S_EMIT_SEL: begin
                if (i_sts.out_free) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.emit_kind = ecpp_pkg::KIND_SELECT;
                    n_state         = S_IDLE;
                end
            end
            S_BAL: begin
                o_ctl.addr_sel = ecpp_pkg::ADDR_CUR;
                if (i_sts.bal_done) begin
                    n_state = S_EMIT_DONE;
                end else if (i_sts.cand) begin
                    o_ctl.cur_latch  = 1'b1;
                    o_ctl.pick_start = 1'b1;
                    n_state          = S_PICK;
                end else begin
                    o_ctl.next_core = 1'b1;
                end
            end
            S_CHK: begin
                if (i_sts.prop_ok) begin
                    n_state = S_EMIT_PROP;
                end else begin
                    o_ctl.next_core = 1'b1;
                    n_state         = S_BAL;
                end
            end
            S_EMIT_PROP: begin
                if (i_sts.out_free) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.emit_kind = ecpp_pkg::KIND_PROPOSAL;
                    n_state         = S_BAL;
                end
            end
            S_EMIT_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.emit_kind = ecpp_pkg::KIND_DONE;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ecpp_dp.sv =====
// -----------------------------------------------------------------------------
// ecpp_dp - placement policy datapath
// Config registers, per-core load and run state, scan unit and result register.
// -----------------------------------------------------------------------------
module ecpp_dp #(
    parameter int MAX_CORES = ecpp_pkg::MAX_CORES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ecpp_pkg::t_in_item   i_in,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  ecpp_pkg::t_ctl       i_ctl,
    output ecpp_pkg::t_sts       o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output ecpp_pkg::t_out_item  o_out
);

    localparam int IW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int NW = $clog2(MAX_CORES + 1);
    localparam logic [4:0] MAX_C5 = 5'(MAX_CORES);

    // config
    logic [3:0] r_core_count;
    logic [7:0] r_mask;
    logic [6:0] r_hi_th;
    logic [6:0] r_lo_th;
    logic [3:0] r_run_len;

    // per-core state
    logic [6:0] r_load [MAX_CORES];
    logic [3:0] r_hrun [MAX_CORES];
    logic [3:0] r_lrun [MAX_CORES];
    logic [MAX_CORES-1:0] big_vec;

    ecpp_pkg::t_in_item r_item;

    // walk pointers
    logic [NW-1:0] r_j;
    logic [NW-1:0] r_i;
    logic [3:0]    r_count;

    // scan unit: best of wanted class and best overall
    logic          r_any_found;
    logic [IW-1:0] r_any_idx;
    logic [6:0]    r_any_load;
    logic          r_cls_found;
    logic [IW-1:0] r_cls_idx;
    logic [6:0]    r_cls_load;

    // core under test in a balance pass
    logic [6:0] r_cur_load;
    logic       r_cur_big;
    logic       r_cur_little;

    logic                r_out_valid;
    ecpp_pkg::t_out_item r_out;

    logic [NW-1:0] n_act;
    logic          cfg_wr;
    logic          clr_state;
    logic [IW-1:0] rd_addr;
    logic [6:0]    rd_load;
    logic [3:0]    rd_hrun;
    logic [3:0]    rd_lrun;
    logic          rd_big;
    logic          id_ok;
    logic          upd_en;
    logic [6:0]    ld_clamp;
    logic [8:0]    old_x3;
    logic [6:0]    v_new;
    logic          v_high;
    logic          v_low;
    logic [3:0]    hr_new;
    logic [3:0]    lr_new;
    logic          want;
    logic          in_cls;
    logic [IW-1:0] pick_t;
    logic [6:0]    pick_load;
    logic          cand_little;
    logic          cand_big;
    logic          emit_prop;
    ecpp_pkg::t_out_item out_next;

    genvar g;
    generate
        for (g = 0; g < MAX_CORES; g++) begin : g_big
            if (g < 8) begin : g_mask
                assign big_vec[g] = r_mask[g];
            end else begin : g_none
                assign big_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign n_act = NW'(({1'b0, r_core_count} > MAX_C5) ? MAX_C5 : {1'b0, r_core_count});

    assign cfg_wr    = i_cfg_valid;
    assign clr_state = cfg_wr && (i_cfg_index == ecpp_pkg::CFG_CORE_COUNT);

    always_comb begin
        case (i_ctl.addr_sel)
            ecpp_pkg::ADDR_SCAN: rd_addr = r_j[IW-1:0];
            ecpp_pkg::ADDR_CUR:  rd_addr = r_i[IW-1:0];
            default:             rd_addr = IW'(r_item.core_id);
        endcase
    end

    assign rd_load = r_load[rd_addr];
    assign rd_hrun = r_hrun[rd_addr];
    assign rd_lrun = r_lrun[rd_addr];
    assign rd_big  = big_vec[rd_addr];

    // load update: load/4 + old*3/4
    assign id_ok    = {2'b00, r_item.core_id} < 5'(n_act);
    assign upd_en   = i_ctl.upd && id_ok;
    assign ld_clamp = (r_item.load_percent > 8'(ecpp_pkg::LOAD_CAP)) ?
                      ecpp_pkg::LOAD_CAP : r_item.load_percent[6:0];
    assign old_x3   = {2'b00, rd_load} * 9'd3;
    assign v_new    = 7'(ld_clamp >> 2) + 7'(old_x3 >> 2);
    assign v_high   = v_new > r_hi_th;
    assign v_low    = v_new < r_lo_th;
    assign hr_new   = !v_high ? 4'd0 :
                      (rd_hrun == ecpp_pkg::RUN_SAT) ? rd_hrun : rd_hrun + 4'd1;
    assign lr_new   = (v_high || !v_low) ? 4'd0 :
                      (rd_lrun == ecpp_pkg::RUN_SAT) ? rd_lrun : rd_lrun + 4'd1;

    // scan: little candidate looks for big, big candidate follows solar
    assign want   = (r_item.cmd == ecpp_pkg::CMD_BALANCE) ?
                    (r_cur_little || r_item.on_solar) : (r_item.wants_big || r_item.on_solar);
    assign in_cls = rd_big == want;

    assign pick_t    = r_cls_found ? r_cls_idx  : r_any_idx;
    assign pick_load = r_cls_found ? r_cls_load : r_any_load;

    assign cand_little = !rd_big && (rd_hrun >= r_run_len);
    assign cand_big    =  rd_big && (rd_lrun >= r_run_len);

    assign emit_prop = i_ctl.emit && (i_ctl.emit_kind == ecpp_pkg::KIND_PROPOSAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count <= '0;
            r_mask       <= '0;
            r_hi_th      <= ecpp_pkg::HI_TH_RST;
            r_lo_th      <= ecpp_pkg::LO_TH_RST;
            r_run_len    <= ecpp_pkg::RUN_LEN_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                ecpp_pkg::CFG_CORE_COUNT: r_core_count <= i_cfg_data[3:0];
                ecpp_pkg::CFG_BIG_MASK:   r_mask       <= i_cfg_data;
                ecpp_pkg::CFG_HIGH_TH:    r_hi_th      <= i_cfg_data[6:0];
                ecpp_pkg::CFG_LOW_TH:     r_lo_th      <= i_cfg_data[6:0];
                ecpp_pkg::CFG_RUN_LEN:    r_run_len    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_state) begin
            for (int k = 0; k < MAX_CORES; k++) begin
                r_load[k] <= '0;
                r_hrun[k] <= '0;
                r_lrun[k] <= '0;
            end
        end else begin
            if (upd_en) begin
                r_load[rd_addr] <= v_new;
                r_hrun[rd_addr] <= hr_new;
                r_lrun[rd_addr] <= lr_new;
            end
            if (emit_prop) begin
                if (r_cur_big) begin
                    r_lrun[r_i[IW-1:0]] <= '0;
                end else begin
                    r_hrun[r_i[IW-1:0]] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_item <= i_in;
        end
        if (i_ctl.cur_latch) begin
            r_cur_load   <= rd_load;
            r_cur_big    <= rd_big;
            r_cur_little <= !rd_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j         <= '0;
            r_i         <= '0;
            r_count     <= '0;
            r_any_found <= 1'b0;
            r_cls_found <= 1'b0;
            r_any_idx   <= '0;
            r_any_load  <= '0;
            r_cls_idx   <= '0;
            r_cls_load  <= '0;
        end else begin
            if (i_ctl.latch_in || i_ctl.pick_start) begin
                r_j         <= '0;
                r_any_found <= 1'b0;
                r_cls_found <= 1'b0;
                r_any_idx   <= '0;
                r_any_load  <= '0;
                r_cls_idx   <= '0;
                r_cls_load  <= '0;
            end else if (i_ctl.pick_step) begin
                r_j <= r_j + NW'(1);
                if (!r_any_found || rd_load < r_any_load) begin
                    r_any_found <= 1'b1;
                    r_any_idx   <= rd_addr;
                    r_any_load  <= rd_load;
                end
                if (in_cls && (!r_cls_found || rd_load < r_cls_load)) begin
                    r_cls_found <= 1'b1;
                    r_cls_idx   <= rd_addr;
                    r_cls_load  <= rd_load;
                end
            end
            if (i_ctl.latch_in) begin
                r_i     <= '0;
                r_count <= '0;
            end else if (i_ctl.next_core) begin
                r_i <= r_i + NW'(1);
            end else if (emit_prop) begin
                r_i     <= r_i + NW'(1);
                r_count <= r_count + 4'd1;
            end
        end
    end

    always_comb begin
        out_next             = '0;
        out_next.result_kind = i_ctl.emit_kind;
        case (i_ctl.emit_kind)
            ecpp_pkg::KIND_SELECT: begin
                out_next.target_core = 3'(pick_t);
                out_next.target_load = pick_load;
                out_next.last        = 1'b1;
            end
            ecpp_pkg::KIND_PROPOSAL: begin
                out_next.source_core = 3'(r_i);
                out_next.target_core = 3'(pick_t);
                out_next.source_load = r_cur_load;
                out_next.target_load = pick_load;
            end
            default: begin
                out_next.proposal_count = r_count;
                out_next.last           = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_sts.cmd       = r_item.cmd;
    assign o_sts.pick_done = r_j >= n_act;
    assign o_sts.bal_done  = (r_i >= n_act) || (r_count == 4'(ecpp_pkg::MAX_PROPOSALS));
    assign o_sts.cand      = cand_little || cand_big;
    assign o_sts.prop_ok   = (pick_t != r_i[IW-1:0]) && (r_cur_big || pick_load < r_cur_load);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/core/ecpp_chk.sv =====
// -----------------------------------------------------------------------------
// ecpp_chk - port checker for the core placement policy
// Watches the top-level ports over time; attached by bind.
// -----------------------------------------------------------------------------
module ecpp_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input ecpp_pkg::t_in_item   i_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ecpp_pkg::t_out_item  o_out
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // only proposals leave a transaction open
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.result_kind == ecpp_pkg::KIND_PROPOSAL) == !o_out.last))
        else $error("last flag disagrees with result kind");

    // an accepted real command drops ready in the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.cmd == ecpp_pkg::CMD_UPDATE ||
         i_in.cmd == ecpp_pkg::CMD_SELECT || i_in.cmd == ecpp_pkg::CMD_BALANCE))
        |=> !o_in_ready)
        else $error("new transaction taken while busy");

    // select results carry no source or count
    a_sel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.result_kind == ecpp_pkg::KIND_SELECT) |->
        (o_out.source_core == 3'd0 && o_out.source_load == 7'd0 &&
         o_out.proposal_count == 4'd0))
        else $error("select result has stray fields");

    // finishing count never exceeds the proposal limit
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.result_kind == ecpp_pkg::KIND_DONE) |->
        (o_out.proposal_count <= 4'(ecpp_pkg::MAX_PROPOSALS) && o_out.target_load == 7'd0))
        else $error("balance count out of range");

endmodule

bind ewma_core_placement_policy ecpp_chk u_ecpp_chk (.*);
